>>> sv/abc_pkg.sv
// ----------------------------------------------------------------------------
// abc_pkg
// Shared types, constants and the mix table for the archive block cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package abc_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned TABLE_COLS  = 256;
    localparam int unsigned TABLE_ROWS  = 5;
    localparam int unsigned TABLE_SLICE = 3;

    localparam logic [WORD_W-1:0] SEED_INIT = 32'hEEEE_EEEE;
    localparam logic [WORD_W-1:0] KEY_ADD   = 32'h1111_1111;
    localparam logic [WORD_W-1:0] LCG_START = 32'h0010_0001;
    localparam logic [WORD_W-1:0] LCG_MOD   = 32'h002A_AAAB;
    localparam logic [WORD_W-1:0] LCG_MUL   = 32'd125;
    localparam logic [WORD_W-1:0] LCG_INC   = 32'd3;
    localparam logic [WORD_W-1:0] SEED_INC  = 32'd3;

    typedef logic [TABLE_COLS-1:0][WORD_W-1:0] mix_table_t;

    // running cipher state carried from word to word
    typedef struct packed {
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] seed;
    } abc_state_t;

    // one step of the table generator, operand stays below 2^22 so 32 bits hold it
    function automatic logic [WORD_W-1:0] lcg_next(input logic [WORD_W-1:0] s);
        logic [WORD_W-1:0] prod;
        prod = s * LCG_MUL + LCG_INC;
        return prod % LCG_MOD;
    endfunction

    // filled column by column; only the fourth row of each column is kept
    function automatic mix_table_t build_mix_table();
        mix_table_t        tbl;
        logic [WORD_W-1:0] s;
        logic [15:0]       hi;
        tbl = '0;
        s   = LCG_START;
        for (int col = 0; col < TABLE_COLS; col++)
        begin
            for (int row = 0; row < TABLE_ROWS; row++)
            begin
                s  = lcg_next(s);
                hi = s[15:0];
                s  = lcg_next(s);
                if (row == TABLE_SLICE)
                begin
                    tbl[col] = {hi, s[15:0]};
                end
            end
        end
        return tbl;
    endfunction

    localparam mix_table_t MIX_TABLE = build_mix_table();

endpackage

`default_nettype wire

>>> sv/archive_block_cipher.sv
// ----------------------------------------------------------------------------
// archive_block_cipher
// Streaming block word cipher with running key and seed.
// ----------------------------------------------------------------------------
// Takes one 32-bit word per transfer and returns one result word per transfer,
// in order. A word with start_of_block set loads block_key and restarts the
// seed; otherwise the key and seed left by the previous word are used, and
// after reset that is key 0 with the initial seed. Throughput is one word per
// cycle while out_ready stays high, set by the combinational key and seed
// recurrence in the round logic, which includes the 256-entry mix table read.
// An accepted word is registered in the input register, then its result is
// registered in the result register once that slot is free or being emptied.
// ----------------------------------------------------------------------------
`default_nettype none

module archive_block_cipher (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [abc_pkg::WORD_W-1:0]   data_word,
    input  wire logic                         start_of_block,
    input  wire logic [abc_pkg::WORD_W-1:0]   block_key,
    input  wire logic                         decrypt,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [abc_pkg::WORD_W-1:0]        result_word
);
    import abc_pkg::*;

    logic              in_valid_reg;
    logic [WORD_W-1:0] word_reg;
    logic              start_reg;
    logic [WORD_W-1:0] key_in_reg;
    logic              decrypt_reg;

    abc_state_t        state_reg;
    abc_state_t        state_next;
    logic [WORD_W-1:0] result_next;
    logic [WORD_W-1:0] result_reg;
    logic              out_valid_reg;

    logic              advance;
    logic              in_xfer;

    // the held word moves on when the result slot is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_xfer  = in_valid && in_ready;

    abc_round u_round (
        .state          (state_reg),
        .data_word      (word_reg),
        .start_of_block (start_reg),
        .block_key      (key_in_reg),
        .decrypt        (decrypt_reg),
        .result_word    (result_next),
        .state_next     (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg.key   <= '0;
            state_reg.seed  <= SEED_INIT;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            word_reg    <= data_word;
            start_reg   <= start_of_block;
            key_in_reg  <= block_key;
            decrypt_reg <= decrypt;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_word = result_reg;

    // a word leaving the input register always lands in the result register
    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result register not filled after advance");

    // a stalled input word keeps its contents
    a_stall_holds_word: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(word_reg)
            && $stable(start_reg) && $stable(decrypt_reg)))
        else $error("stalled input word changed");

    // cipher state moves only with a word
    a_state_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("cipher state changed without a word");

    // an accepted word is held in the input register next cycle
    a_xfer_loads_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> in_valid_reg)
        else $error("accepted word not registered");

endmodule

`default_nettype wire

>>> sv/abc_round.sv
// ----------------------------------------------------------------------------
// abc_round
// One cipher step: result word and next key and seed from the current state.
// ----------------------------------------------------------------------------
`default_nettype none

module abc_round (
    input  wire abc_pkg::abc_state_t              state,
    input  wire logic [abc_pkg::WORD_W-1:0]       data_word,
    input  wire logic                             start_of_block,
    input  wire logic [abc_pkg::WORD_W-1:0]       block_key,
    input  wire logic                             decrypt,
    output logic [abc_pkg::WORD_W-1:0]            result_word,
    output abc_pkg::abc_state_t                   state_next
);
    import abc_pkg::*;

    logic [WORD_W-1:0] k;
    logic [WORD_W-1:0] s0;
    logic [WORD_W-1:0] s;
    logic [WORD_W-1:0] plain;

    always_comb
    begin
        // a start re-keys and restarts the seed before this word
        k           = start_of_block ? block_key : state.key;
        s0          = start_of_block ? SEED_INIT : state.seed;
        s           = s0 + MIX_TABLE[k[7:0]];
        result_word = data_word ^ (k + s);
        plain       = decrypt ? result_word : data_word;

        state_next.key  = ({~k[10:0], 21'd0} + KEY_ADD) | {11'd0, k[31:11]};
        // seed * 33 as a shift and add
        state_next.seed = s + {s[26:0], 5'd0} + plain + SEED_INC;
    end

endmodule

`default_nettype wire
